// ----- rtl/rpk_pkg.sv -----
// shared types and constants for the packed entry width repacker
`default_nettype none

package rpk_pkg;

    localparam int unsigned WORD_BITS  = 64;
    localparam int unsigned WIDTH_W    = 5;
    localparam int unsigned VAL_W      = 31;
    localparam int unsigned POS_W      = 7;
    localparam int unsigned CFG_DATA_W = 13;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [WIDTH_W-1:0]    OLD_WIDTH_RST = 5'd4;
    localparam logic [WIDTH_W-1:0]    NEW_WIDTH_RST = 5'd4;
    localparam logic [CFG_DATA_W-1:0] COUNT_RST     = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OLD_WIDTH   = 2'd0,
        CFG_NEW_WIDTH   = 2'd1,
        CFG_ENTRY_COUNT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] value;
        logic             done;
    } t_entry;

endpackage

`default_nettype wire

// ----- rtl/rpk_in_if.sv -----
// input channel carrying packed input words
`default_nettype none

interface rpk_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] in_word;

    modport source (output valid, output in_word, input ready);
    modport sink   (input valid, input in_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/rpk_out_if.sv -----
// output channel carrying repacked words and the last flag
`default_nettype none

interface rpk_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_word;
    logic        out_last;

    modport source (output valid, output out_word, output out_last, input ready);
    modport sink   (input valid, input out_word, input out_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/rpk_unpack_seq.sv -----
// sequencer that steps through the entries of one input word with a shared shifter
`default_nettype none

module rpk_unpack_seq #(
    parameter int unsigned CNT_W = 13
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_clear,
    input  wire logic [rpk_pkg::WIDTH_W-1:0]  i_old_width,
    input  wire logic [rpk_pkg::WIDTH_W-1:0]  i_new_width,
    input  wire logic [CNT_W-1:0]             i_count,
    rpk_in_if.sink                            i_in,
    input  wire logic                         i_pack_ready,
    output rpk_pkg::t_entry                   o_entry
);
    import rpk_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state                 r_state;
    logic [WORD_BITS-1:0]   r_word;
    logic [POS_W-1:0]       r_bit;
    logic [CNT_W-1:0]       r_cnt;

    logic [VAL_W-1:0]       mask_old;
    logic [VAL_W-1:0]       mask_new;
    logic [CNT_W-1:0]       cnt_inc;
    logic                   done;
    logic                   fits_next;

    assign mask_old  = {VAL_W{1'b1}} >> (WIDTH_W'(VAL_W) - i_old_width);
    assign mask_new  = {VAL_W{1'b1}} >> (WIDTH_W'(VAL_W) - i_new_width);
    assign cnt_inc   = r_cnt + CNT_W'(1);
    assign done      = cnt_inc >= i_count;
    assign fits_next = (8'(r_bit) + 8'(i_old_width) + 8'(i_old_width)) <= 8'(WORD_BITS);

    assign o_entry.valid = (r_state == S_RUN);
    assign o_entry.value = r_word[VAL_W-1:0] & mask_old & mask_new;
    assign o_entry.done  = done;

    assign i_in.ready = (r_state == S_IDLE) && !i_clear;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_cnt   <= '0;
        end else if (i_clear) begin
            r_state <= S_IDLE;
            r_bit   <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_word  <= i_in.in_word;
                        r_bit   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (i_pack_ready) begin
                        r_word <= r_word >> i_old_width;
                        r_bit  <= r_bit + POS_W'(i_old_width);
                        if (done) begin
                            r_cnt   <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt <= cnt_inc;
                            if (!fits_next) begin
                                r_state <= S_IDLE;
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_run_below_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_cnt < i_count))
        else $error("entry counter reached the count while stepping");

    a_run_entry_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ((8'(r_bit) + 8'(i_old_width)) <= 8'(WORD_BITS)))
        else $error("entry extends past the input word");

endmodule

`default_nettype wire

// ----- rtl/rpk_pack_unit.sv -----
// assembles entries into output words and holds the output register
`default_nettype none

module rpk_pack_unit (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_clear,
    input  wire logic [rpk_pkg::WIDTH_W-1:0]  i_new_width,
    input  wire rpk_pkg::t_entry              i_entry,
    output logic                              o_ready,
    rpk_out_if.source                         o_out
);
    import rpk_pkg::*;

    logic [WORD_BITS-1:0]   r_asm;
    logic [POS_W-1:0]       r_pos;
    logic                   r_out_valid;
    logic [WORD_BITS-1:0]   r_out_word;
    logic                   r_out_last;

    logic [WORD_BITS-1:0]   n_asm;
    logic [POS_W-1:0]       n_pos;
    logic                   take;
    logic                   flush;

    assign o_ready = !r_out_valid || o_out.ready;
    assign take    = i_entry.valid && o_ready;
    assign n_asm   = r_asm | (WORD_BITS'(i_entry.value) << r_pos[POS_W-2:0]);
    assign n_pos   = r_pos + POS_W'(i_new_width);
    assign flush   = i_entry.done || ((8'(n_pos) + 8'(i_new_width)) > 8'(WORD_BITS));

    assign o_out.valid    = r_out_valid;
    assign o_out.out_word = r_out_word;
    assign o_out.out_last = r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_asm       <= '0;
            r_pos       <= '0;
        end else if (i_clear) begin
            r_asm <= '0;
            r_pos <= '0;
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end else begin
            if (take && flush) begin
                r_out_word  <= n_asm;
                r_out_last  <= i_entry.done;
                r_out_valid <= 1'b1;
                r_asm       <= '0;
                r_pos       <= '0;
            end else begin
                if (o_out.ready) begin
                    r_out_valid <= 1'b0;
                end
                if (take) begin
                    r_asm <= n_asm;
                    r_pos <= n_pos;
                end
            end
        end
    end

    a_pos_in_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < POS_W'(WORD_BITS))
        else $error("assembly position left the output word");

    a_last_flushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_entry.done && !i_clear) |=> (r_out_valid && r_out_last && (r_pos == '0)))
        else $error("final entry did not flush a last word");

endmodule

`default_nettype wire

// ----- rtl/packed_entry_width_repacker.sv -----
// top level: repacks arrays of packed entries from one entry width to another
// output: a word is registered and valid in the cycle after the entry that completes it
// throughput: a new input word is taken only while the sequencer is idle, after the
//   last entry of the previous word or at the end of the array; one entry per cycle
//   goes through the shared shifter and an output register stall holds the step
// reset: synchronous active low, widths return to 4, count to 4096, assembly clear
`default_nettype none

module packed_entry_width_repacker #(
    parameter int unsigned MAX_ENTRIES = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [rpk_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [rpk_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    rpk_in_if.sink                               i_in,
    rpk_out_if.source                            o_out
);
    import rpk_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned KW    = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;

    logic [WIDTH_W-1:0]    r_old_width;
    logic [WIDTH_W-1:0]    r_new_width;
    logic [CFG_DATA_W-1:0] r_count;

    logic [WIDTH_W-1:0]    old_eff;
    logic [WIDTH_W-1:0]    new_eff;
    logic [KW-1:0]         cnt_ext;
    logic [CNT_W-1:0]      cnt_eff;
    logic                  clear;
    logic                  pack_ready;
    t_entry                entry;

    assign old_eff = (r_old_width == '0) ? WIDTH_W'(1) : r_old_width;
    assign new_eff = (r_new_width == '0) ? WIDTH_W'(1) : r_new_width;
    assign cnt_ext = KW'(r_count);
    assign cnt_eff = (r_count == '0)               ? CNT_W'(1) :
                     (cnt_ext > KW'(MAX_ENTRIES))  ? CNT_W'(MAX_ENTRIES) :
                                                     CNT_W'(cnt_ext);

    always_comb begin
        case (i_cfg_index)
            CFG_OLD_WIDTH, CFG_NEW_WIDTH, CFG_ENTRY_COUNT: clear = i_cfg_we;
            default: clear = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_width <= OLD_WIDTH_RST;
            r_new_width <= NEW_WIDTH_RST;
            r_count     <= COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_OLD_WIDTH: begin
                    r_old_width <= i_cfg_data[WIDTH_W-1:0];
                end
                CFG_NEW_WIDTH: begin
                    r_new_width <= i_cfg_data[WIDTH_W-1:0];
                end
                CFG_ENTRY_COUNT: begin
                    r_count <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    rpk_unpack_seq #(
        .CNT_W (CNT_W)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_clear      (clear),
        .i_old_width  (old_eff),
        .i_new_width  (new_eff),
        .i_count      (cnt_eff),
        .i_in         (i_in),
        .i_pack_ready (pack_ready),
        .o_entry      (entry)
    );

    rpk_pack_unit u_pack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (clear),
        .i_new_width (new_eff),
        .i_entry     (entry),
        .o_ready     (pack_ready),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire
